FILE: rtl/core/hnd_pkg.sv
// Shared types and constants for the Huffman node-table decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hnd_pkg;

  // Input kinds carried on in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam int unsigned CHILD_W = 9;
  localparam int unsigned ENTRY_W = 2 * CHILD_W;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned BIT_W   = 3;

  typedef logic [CHILD_W-1:0] child_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } walk_state_t;

  // One decoded symbol handed from the walker to the output stage
  typedef struct packed {
    logic valid;
    sym_t symbol;
    logic run_last;
    logic chunk_done;
  } sym_push_t;

endpackage

`default_nettype wire

FILE: rtl/core/hnd_node_mem.sv
// Node table memory: one 18-bit entry (child one, child zero) per node.
// One write port, one read port with registered read data. Uses hnd_pkg.
`default_nettype none

module hnd_node_mem
  import hnd_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 255,
  parameter int unsigned AW         = 8
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [ENTRY_W-1:0] rdata_r
);

  logic [ENTRY_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/hnd_walker.sv
// Tree walker: shifts a compressed byte out one bit per cycle unless a
// decoded symbol waits on a busy output stage, follows one table lookup per
// bit and holds the newest symbol until its run_last is known. Uses hnd_pkg.
`default_nettype none

module hnd_walker
  import hnd_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 255,
  parameter int unsigned AW         = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire sym_t               data_byte,
  input  wire logic               len_we,
  input  wire len_t               len_wdata,
  input  wire logic [ENTRY_W-1:0] entry,
  input  wire logic               out_free,
  output logic                    idle,
  output logic      [AW-1:0]      raddr,
  output sym_push_t               push
);

  localparam logic [AW-1:0] HEAD = AW'(NODE_COUNT - 1);

  walk_state_t       state_r, state_nxt;
  logic [AW-1:0]     node_r, node_nxt;
  sym_t              bits_r, bits_nxt;
  logic [BIT_W-1:0]  cnt_r, cnt_nxt;
  len_t              len_r, len_nxt;
  len_t              emit_r, emit_nxt;
  logic              pend_v_r, pend_v_nxt;
  sym_t              pend_sym_r, pend_sym_nxt;
  logic              pend_done_r, pend_done_nxt;

  child_t            child;
  logic              leaf;
  logic              ptr_ok;
  len_t              emit_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      node_r   <= HEAD;
      len_r    <= '0;
      emit_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      node_r   <= node_nxt;
      len_r    <= len_nxt;
      emit_r   <= emit_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r      <= bits_nxt;
    cnt_r       <= cnt_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_done_r <= pend_done_nxt;
  end

  assign child    = bits_r[0] ? entry[ENTRY_W-1:CHILD_W] : entry[CHILD_W-1:0];
  assign leaf     = !child[CHILD_W-1];
  assign ptr_ok   = {1'b0, child[SYM_W-1:0]} < 9'(NODE_COUNT);
  assign emit_inc = emit_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    emit_nxt      = emit_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_done_nxt = pend_done_r;
    push          = '0;
    idle          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (len_we) begin
          len_nxt  = len_wdata;
          emit_nxt = '0;
          node_nxt = HEAD;
        end
        if (start) begin
          bits_nxt  = data_byte;
          cnt_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        if (emit_r >= len_r) begin
          // chunk complete: drop the rest of the byte
          state_nxt = ST_FLUSH;
        end else if (!(leaf && pend_v_r && !out_free)) begin
          bits_nxt = bits_r >> 1;
          cnt_nxt  = cnt_r + 1'b1;
          if (leaf) begin
            if (pend_v_r) begin
              push.valid      = 1'b1;
              push.symbol     = pend_sym_r;
              push.run_last   = 1'b0;
              push.chunk_done = pend_done_r;
            end
            pend_v_nxt    = 1'b1;
            pend_sym_nxt  = child[SYM_W-1:0];
            pend_done_nxt = (emit_inc == len_r);
            emit_nxt      = emit_inc;
            node_nxt      = HEAD;
          end else if (ptr_ok) begin
            node_nxt = child[AW-1:0];
          end else begin
            node_nxt = HEAD;
          end
          if (cnt_r == {BIT_W{1'b1}}) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push.valid      = 1'b1;
          push.symbol     = pend_sym_r;
          push.run_last   = 1'b1;
          push.chunk_done = pend_done_r;
          pend_v_nxt      = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Always read the node the walk will stand on next cycle
  assign raddr = node_nxt;

endmodule

`default_nettype wire

FILE: rtl/core/hnd_out_stage.sv
// Output register for decoded symbols; frees the walker from the sink.
// Uses hnd_pkg.
`default_nettype none

module hnd_out_stage
  import hnd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sym_push_t push,
  output logic           out_free,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [0:0]     out_tuser
);

  logic valid_r;
  sym_t sym_r;
  logic last_r;
  logic done_r;

  assign out_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      sym_r  <= push.symbol;
      last_r <= push.run_last;
      done_r <= push.chunk_done;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = sym_r;
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

endmodule

`default_nettype wire

FILE: rtl/core/huffman_node_table_decoder_top.sv
// Huffman node-table decoder, top level. Uses hnd_pkg, hnd_node_mem,
// hnd_walker and hnd_out_stage.
// A load item writes the table while the walker stays idle. A data item is
// walked with one table lookup per bit over 8 bits, then its last symbol is
// handed off, ending early once the chunk completes; output stalls hold it.
// Synchronous active-low reset clears control state, length and count; the
// node table is not cleared.
`default_nettype none

module huffman_node_table_decoder_top
  import hnd_pkg::*;
#(
  parameter int unsigned NODE_COUNT = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: node_index[7:0], child_zero[16:8], child_one[25:17],
  //           data_byte[33:26], zero [39:34]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,
  // in_tuser: opcode[0]
  input  wire logic [0:0]  in_tuser,
  // cfg_tdata: out_length[30:0], zero [31]
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  input  wire logic [31:0] cfg_tdata,
  // out_tdata: symbol[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  // out_tuser: chunk_done[0]
  output logic [0:0]       out_tuser
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  logic               in_acc;
  logic [7:0]         node_index;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_q;
  logic [AW-1:0]      mem_raddr;
  logic               walk_idle;
  logic               out_free;
  sym_push_t          push;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = walk_idle;
  // Hold length writes while a byte is being walked
  assign cfg_tready = walk_idle;
  assign node_index = in_tdata[7:0];

  // Drop loads aimed past the table
  assign mem_we = in_acc && (in_tuser[0] == OP_LOAD) &&
                  ({1'b0, node_index} < 9'(NODE_COUNT));

  hnd_node_mem #(
    .NODE_COUNT(NODE_COUNT),
    .AW        (AW)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (node_index[AW-1:0]),
    .wdata  ({in_tdata[25:17], in_tdata[16:8]}),
    .raddr  (mem_raddr),
    .rdata_r(mem_q)
  );

  hnd_walker #(
    .NODE_COUNT(NODE_COUNT),
    .AW        (AW)
  ) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && (in_tuser[0] == OP_DATA)),
    .data_byte(in_tdata[33:26]),
    .len_we   (cfg_tvalid && cfg_tready),
    .len_wdata(cfg_tdata[LEN_W-1:0]),
    .entry    (mem_q),
    .out_free (out_free),
    .idle     (walk_idle),
    .raddr    (mem_raddr),
    .push     (push)
  );

  hnd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_free  (out_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire
